### sv/fpr_pkg.sv
package fpr_pkg;

  localparam int NUM_FRAMES        = 16;
  localparam int NUM_PROCESSES     = 16;
  localparam int PAGES_PER_PROCESS = 8;
  localparam int TABLE_SIZE        = NUM_PROCESSES * PAGES_PER_PROCESS;

  localparam int PID_W    = 4;
  localparam int PAGE_W   = 3;
  localparam int FRAME_W  = 4;
  localparam int TABLE_AW = PID_W + PAGE_W;
  localparam int FILL_W   = $clog2(NUM_FRAMES + 1);
  localparam int LIMIT_W  = 5;
  localparam int CNT_W    = 32;
  localparam int OWNER_W  = PID_W + PAGE_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(NUM_FRAMES);

  typedef logic [PID_W-1:0]    pid_t;
  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [TABLE_AW-1:0] entry_t;
  typedef logic [LIMIT_W-1:0]  limit_t;
  typedef logic [CNT_W-1:0]    count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVICT,
    ST_WRITE
  } fpr_state_t;

endpackage

### sv/fpr_ram.sv
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/fifo_page_replacement_top.sv
// FIFO page replacement unit. Pulse start with a process id and page number
// while busy is low; the access is looked up in the page table and one result
// word comes back on the out_ ports, marked by out_valid for exactly one
// cycle. The receiver cannot stall: take the word in the cycle it is shown.
// A hit returns to idle straight from the lookup, a miss into a free frame
// goes on to a table write, and a miss that evicts the oldest frame also
// passes an evict step before the write. The page table, FIFO slot and frame
// owner memories have registered reads and a single read and write port each:
// lookup, then owner read and old-owner clear, then table write. The result
// word shows in the cycle busy falls, so a new start may be taken while it is
// on the ports. Write frames_in_use through cfg_we/cfg_wdata only while idle;
// 0 acts as 1 and values above the frame count act as the frame count.
module fifo_page_replacement_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  fpr_pkg::pid_t   in_process_id,
  input  fpr_pkg::page_t  in_page_number,
  output logic            out_valid,
  output logic            out_was_hit,
  output fpr_pkg::frame_t out_frame_index,
  output logic            out_did_evict,
  output fpr_pkg::pid_t   out_evicted_process,
  output fpr_pkg::page_t  out_evicted_page,
  output fpr_pkg::count_t out_hit_count,
  output fpr_pkg::count_t out_fault_count,
  input  logic            cfg_we,
  input  fpr_pkg::limit_t cfg_wdata
);

  import fpr_pkg::*;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  // sequencer state
  fpr_state_t state_r, state_nxt;

  // access being worked on
  pid_t   pid_r, pid_nxt;
  page_t  page_r, page_nxt;
  frame_t frame_r, frame_nxt;
  logic   evict_r, evict_nxt;
  pid_t   ev_pid_r, ev_pid_nxt;
  page_t  ev_page_r, ev_page_nxt;

  // present bits live in flops so reset clears them at once
  logic [TABLE_SIZE-1:0] present_r, present_nxt;
  logic [NUM_FRAMES-1:0] used_r, used_nxt;

  logic [FRAME_W-1:0] head_r, head_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  count_t             hit_total_r, hit_total_nxt;
  count_t             fault_total_r, fault_total_nxt;
  limit_t             limit_r;

  // result word registers
  logic   out_valid_r, out_valid_nxt;
  logic   out_hit_r, out_hit_nxt;
  frame_t out_frame_r, out_frame_nxt;
  logic   out_evict_r, out_evict_nxt;
  pid_t   out_ev_pid_r, out_ev_pid_nxt;
  page_t  out_ev_page_r, out_ev_page_nxt;
  count_t out_hits_r, out_hits_nxt;
  count_t out_faults_r, out_faults_nxt;

  // memory ports
  logic   pt_we;
  frame_t pt_rdata;
  logic   own_we;
  logic [OWNER_W-1:0] own_rdata;
  logic   fifo_we;
  frame_t fifo_waddr;
  frame_t fifo_rdata;

  entry_t entry_r;
  limit_t limit_eff;
  logic   free_found;
  frame_t free_idx;
  logic   page_hit;
  logic [FILL_W:0] tail_sum;

  assign entry_r  = {pid_r, page_r};
  assign page_hit = present_r[entry_r];
  assign tail_sum = (FILL_W + 1)'(head_r) + (FILL_W + 1)'(fill_r);
  assign fifo_waddr = FRAME_W'(tail_sum % NUM_FRAMES);

  // Page table: frame number of each (process, page). Read at the incoming
  // access every cycle, so the data is ready in the lookup state.
  fpr_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (TABLE_SIZE)
  ) u_page_table (
    .clk     (clk),
    .wr_en   (pt_we),
    .wr_addr (entry_r),
    .wr_data (frame_r),
    .rd_addr ({in_process_id, in_page_number}),
    .rd_data (pt_rdata)
  );

  // Load order of frames; head slot is always being read.
  fpr_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (NUM_FRAMES)
  ) u_fifo_slots (
    .clk     (clk),
    .wr_en   (fifo_we),
    .wr_addr (fifo_waddr),
    .wr_data (frame_r),
    .rd_addr (head_r),
    .rd_data (fifo_rdata)
  );

  // Owner of each frame. Addressed by the frame read from the head slot, so the
  // owner of the victim is ready in the cycle after the lookup picks it.
  fpr_ram #(
    .WIDTH (OWNER_W),
    .DEPTH (NUM_FRAMES)
  ) u_frame_owner (
    .clk     (clk),
    .wr_en   (own_we),
    .wr_addr (frame_r),
    .wr_data ({pid_r, page_r}),
    .rd_addr (fifo_rdata),
    .rd_data (own_rdata)
  );

  // Clamp the frame limit into 1..NUM_FRAMES.
  always_comb begin
    if (limit_r == '0) begin
      limit_eff = LIMIT_W'(1);
    end else if (limit_r > LIMIT_W'(NUM_FRAMES)) begin
      limit_eff = LIMIT_W'(NUM_FRAMES);
    end else begin
      limit_eff = limit_r;
    end
  end

  // Lowest free frame below the limit; scan from the top so the lowest wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!used_r[i] && (LIMIT_W'(i) < limit_eff)) begin
        free_found = 1'b1;
        free_idx   = FRAME_W'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        priority if (page_hit) begin
          state_nxt = ST_IDLE;
        end else if (!free_found && (fill_r != '0)) begin
          state_nxt = ST_EVICT;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_EVICT: state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pid_nxt         = pid_r;
    page_nxt        = page_r;
    frame_nxt       = frame_r;
    evict_nxt       = evict_r;
    ev_pid_nxt      = ev_pid_r;
    ev_page_nxt     = ev_page_r;
    present_nxt     = present_r;
    used_nxt        = used_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    hit_total_nxt   = hit_total_r;
    fault_total_nxt = fault_total_r;
    pt_we           = 1'b0;
    own_we          = 1'b0;
    fifo_we         = 1'b0;
    out_valid_nxt   = 1'b0;
    out_hit_nxt     = out_hit_r;
    out_frame_nxt   = out_frame_r;
    out_evict_nxt   = out_evict_r;
    out_ev_pid_nxt  = out_ev_pid_r;
    out_ev_page_nxt = out_ev_page_r;
    out_hits_nxt    = out_hits_r;
    out_faults_nxt  = out_faults_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          pid_nxt  = in_process_id;
          page_nxt = in_page_number;
        end
      end
      ST_LOOK: begin
        priority if (page_hit) begin
          hit_total_nxt   = sat_inc(hit_total_r);
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = 1'b1;
          out_frame_nxt   = pt_rdata;
          out_evict_nxt   = 1'b0;
          out_ev_pid_nxt  = '0;
          out_ev_page_nxt = '0;
          out_hits_nxt    = hit_total_nxt;
          out_faults_nxt  = fault_total_r;
        end else if (free_found) begin
          fault_total_nxt = sat_inc(fault_total_r);
          frame_nxt       = free_idx;
          evict_nxt       = 1'b0;
        end else if (fill_r != '0) begin
          // pop the oldest frame; its owner is read next cycle
          fault_total_nxt = sat_inc(fault_total_r);
          frame_nxt       = fifo_rdata;
          evict_nxt       = 1'b1;
          head_nxt        = (head_r == FRAME_W'(NUM_FRAMES - 1)) ? '0
                                                                 : head_r + FRAME_W'(1);
          fill_nxt        = fill_r - FILL_W'(1);
        end else begin
          fault_total_nxt = sat_inc(fault_total_r);
          frame_nxt       = '0;
          evict_nxt       = 1'b0;
        end
      end
      ST_EVICT: begin
        // drop the old owner's mapping
        ev_pid_nxt  = own_rdata[OWNER_W-1:PAGE_W];
        ev_page_nxt = own_rdata[PAGE_W-1:0];
        present_nxt[entry_t'({own_rdata[OWNER_W-1:PAGE_W], own_rdata[PAGE_W-1:0]})] = 1'b0;
      end
      ST_WRITE: begin
        pt_we                = 1'b1;
        own_we               = 1'b1;
        present_nxt[entry_r] = 1'b1;
        used_nxt[frame_r]    = 1'b1;
        if (fill_r < FILL_W'(NUM_FRAMES)) begin
          fifo_we  = 1'b1;
          fill_nxt = fill_r + FILL_W'(1);
        end
        out_valid_nxt   = 1'b1;
        out_hit_nxt     = 1'b0;
        out_frame_nxt   = frame_r;
        out_evict_nxt   = evict_r;
        out_ev_pid_nxt  = evict_r ? ev_pid_r : '0;
        out_ev_page_nxt = evict_r ? ev_page_r : '0;
        out_hits_nxt    = hit_total_r;
        out_faults_nxt  = fault_total_r;
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      present_r     <= '0;
      used_r        <= '0;
      head_r        <= '0;
      fill_r        <= '0;
      hit_total_r   <= '0;
      fault_total_r <= '0;
      limit_r       <= LIMIT_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      present_r     <= present_nxt;
      used_r        <= used_nxt;
      head_r        <= head_nxt;
      fill_r        <= fill_nxt;
      hit_total_r   <= hit_total_nxt;
      fault_total_r <= fault_total_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // Payload; hold unless the sequencer changes it.
  always_ff @(posedge clk) begin
    pid_r         <= pid_nxt;
    page_r        <= page_nxt;
    frame_r       <= frame_nxt;
    evict_r       <= evict_nxt;
    ev_pid_r      <= ev_pid_nxt;
    ev_page_r     <= ev_page_nxt;
    out_hit_r     <= out_hit_nxt;
    out_frame_r   <= out_frame_nxt;
    out_evict_r   <= out_evict_nxt;
    out_ev_pid_r  <= out_ev_pid_nxt;
    out_ev_page_r <= out_ev_page_nxt;
    out_hits_r    <= out_hits_nxt;
    out_faults_r  <= out_faults_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_was_hit         = out_hit_r;
  assign out_frame_index     = out_frame_r;
  assign out_did_evict       = out_evict_r;
  assign out_evicted_process = out_ev_pid_r;
  assign out_evicted_page    = out_ev_page_r;
  assign out_hit_count       = out_hits_r;
  assign out_fault_count     = out_faults_r;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fpr_pkg::*;

  // One result word as the block shows it on the out_ ports.
  typedef struct packed {
    logic   was_hit;
    frame_t frame_index;
    logic   did_evict;
    pid_t   evicted_process;
    page_t  evicted_page;
    count_t hit_count;
    count_t fault_count;
  } access_word_t;

  // One row of the directed script: either a frame limit write or an access,
  // optionally with the result word typed in by hand.
  typedef struct packed {
    logic         is_limit;
    limit_t       limit;
    pid_t         pid;
    page_t        page;
    logic         typed;
    access_word_t want;
  } script_row_t;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  pid_t   in_process_id;
  page_t  in_page_number;
  logic   out_valid;
  logic   out_was_hit;
  frame_t out_frame_index;
  logic   out_did_evict;
  pid_t   out_evicted_process;
  page_t  out_evicted_page;
  count_t out_hit_count;
  count_t out_fault_count;
  logic   cfg_we;
  limit_t cfg_wdata;

  fifo_page_replacement_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_process_id       (in_process_id),
    .in_page_number      (in_page_number),
    .out_valid           (out_valid),
    .out_was_hit         (out_was_hit),
    .out_frame_index     (out_frame_index),
    .out_did_evict       (out_did_evict),
    .out_evicted_process (out_evicted_process),
    .out_evicted_page    (out_evicted_page),
    .out_hit_count       (out_hit_count),
    .out_fault_count     (out_fault_count),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: the slowest legal run is well under a millisecond.
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the page table, frame owners and
  // the FIFO of loaded frames, plus the frame limit register.
  // ---------------------------------------------------------------------
  logic   present_map [TABLE_SIZE];
  frame_t frame_of    [TABLE_SIZE];
  logic   frame_taken [NUM_FRAMES];
  pid_t   owner_pid   [NUM_FRAMES];
  page_t  owner_page  [NUM_FRAMES];
  frame_t load_order  [NUM_FRAMES];
  frame_t order_head;
  logic [FILL_W-1:0] order_fill;
  count_t hits_seen;
  count_t faults_seen;
  limit_t frame_limit;

  access_word_t expected_words [$];
  script_row_t  script [$];
  int           errors;

  // Work out the result word of one access and advance the predictor.
  function automatic access_word_t replace_page(pid_t pid, page_t page);
    access_word_t w;
    entry_t       e;
    int           lim;
    logic         found;
    frame_t       f;
    w = '0;
    e = {pid, page};
    f = '0;
    if (present_map[e]) begin
      w.was_hit     = 1'b1;
      w.frame_index = frame_of[e];
      if (hits_seen != '1) hits_seen = hits_seen + 1;
    end else begin
      if (faults_seen != '1) faults_seen = faults_seen + 1;
      // Clamp the limit: 0 behaves as 1, anything past the frame count as the count.
      lim = int'(frame_limit);
      if (lim == 0) lim = 1;
      if (lim > NUM_FRAMES) lim = NUM_FRAMES;
      found = 1'b0;
      for (int i = 0; i < lim; i++) begin
        if (!frame_taken[i]) begin
          f     = frame_t'(i);
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        // No free frame below the limit: evict the oldest loaded frame.
        if (order_fill > 0) begin
          f          = load_order[order_head];
          order_head = order_head + 1'b1;
          order_fill = order_fill - 1'b1;
          w.did_evict       = 1'b1;
          w.evicted_process = owner_pid[f];
          w.evicted_page    = owner_page[f];
          present_map[{owner_pid[f], owner_page[f]}] = 1'b0;
        end
      end
      frame_taken[f] = 1'b1;
      owner_pid[f]   = pid;
      owner_page[f]  = page;
      present_map[e] = 1'b1;
      frame_of[e]    = f;
      if (order_fill < NUM_FRAMES) begin
        load_order[frame_t'(order_head + order_fill)] = f;
        order_fill = order_fill + 1'b1;
      end
      w.frame_index = f;
    end
    w.hit_count   = hits_seen;
    w.fault_count = faults_seen;
    return w;
  endfunction

  function automatic script_row_t access_row(pid_t pid, page_t page);
    script_row_t r;
    r      = '0;
    r.pid  = pid;
    r.page = page;
    return r;
  endfunction

  function automatic script_row_t checked_row(pid_t pid, page_t page, logic hit, frame_t fr,
                                              logic ev, pid_t ev_pid, page_t ev_page,
                                              count_t hits, count_t faults);
    script_row_t r;
    r       = access_row(pid, page);
    r.typed = 1'b1;
    r.want  = '{hit, fr, ev, ev_pid, ev_page, hits, faults};
    return r;
  endfunction

  function automatic script_row_t limit_row(limit_t v);
    script_row_t r;
    r          = '0;
    r.is_limit = 1'b1;
    r.limit    = v;
    return r;
  endfunction

  // Present one access word after a gap and hold it until the block takes it.
  // The predicted (or hand-typed) result is queued at the accepting edge.
  task automatic send_access(pid_t pid, page_t page, int gap, logic typed,
                             access_word_t typed_word);
    access_word_t w;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start          <= 1'b1;
    in_process_id  <= pid;
    in_page_number <= page;
    do @(posedge clk); while (busy);
    w = replace_page(pid, page);
    expected_words.push_back(typed ? typed_word : w);
  endtask

  // Write the frame limit only once the block has drained and gone idle.
  task automatic write_limit(limit_t v);
    @(negedge clk);
    start <= 1'b0;
    while (expected_words.size() != 0 || busy) @(posedge clk);
    // Wait out the longest access before the write.
    repeat (6) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    frame_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Result monitor: the block shows each word for one cycle only, so take
  // it at the edge that ends that cycle and compare against the oldest
  // expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    access_word_t want;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (out_was_hit !== want.was_hit) begin
          $error("was_hit: expected %0d, got %0d", want.was_hit, out_was_hit);
          errors++;
        end
        if (out_frame_index !== want.frame_index) begin
          $error("frame_index: expected %0d, got %0d", want.frame_index, out_frame_index);
          errors++;
        end
        if (out_did_evict !== want.did_evict) begin
          $error("did_evict: expected %0d, got %0d", want.did_evict, out_did_evict);
          errors++;
        end
        if (out_evicted_process !== want.evicted_process) begin
          $error("evicted_process: expected %0d, got %0d", want.evicted_process,
                 out_evicted_process);
          errors++;
        end
        if (out_evicted_page !== want.evicted_page) begin
          $error("evicted_page: expected %0d, got %0d", want.evicted_page, out_evicted_page);
          errors++;
        end
        if (out_hit_count !== want.hit_count) begin
          $error("hit_count: expected %0d, got %0d", want.hit_count, out_hit_count);
          errors++;
        end
        if (out_fault_count !== want.fault_count) begin
          $error("fault_count: expected %0d, got %0d", want.fault_count, out_fault_count);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    limit_t limit_pick [8];
    pid_t   hot_pid    [24];
    page_t  hot_page   [24];
    int     sent;
    int     phase_len;
    int     hot_size;
    int     quiet;
    int     gap;
    int     pick;
    int     waited;
    pid_t   pid;
    page_t  page;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_process_id  = '0;
    in_page_number = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    errors         = 0;

    // Predictor after reset: nothing present, no frame taken, FIFO empty.
    for (int i = 0; i < TABLE_SIZE; i++) begin
      present_map[i] = 1'b0;
      frame_of[i]    = '0;
    end
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frame_taken[i] = 1'b0;
      owner_pid[i]   = '0;
      owner_page[i]  = '0;
      load_order[i]  = '0;
    end
    order_head  = '0;
    order_fill  = '0;
    hits_seen   = '0;
    faults_seen = '0;
    frame_limit = LIMIT_RESET;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed script. Hand-typed words cover the start after reset, the
    // corner ids and the first evictions; the rest go through the predictor.
    script.push_back(checked_row(0, 0, 0, 0, 0, 0, 0, 0, 1));    // cold miss, frame 0
    script.push_back(checked_row(0, 0, 1, 0, 0, 0, 0, 1, 1));    // hit
    script.push_back(checked_row(15, 7, 0, 1, 0, 0, 0, 1, 2));   // top ids, next free frame
    script.push_back(checked_row(15, 7, 1, 1, 0, 0, 0, 2, 2));
    script.push_back(limit_row(1));                              // lower limit under load
    script.push_back(checked_row(3, 5, 0, 0, 1, 0, 0, 2, 3));    // evict oldest (frame 0)
    script.push_back(checked_row(15, 7, 1, 1, 0, 0, 0, 3, 3));   // frame above limit still hits
    script.push_back(checked_row(0, 0, 0, 1, 1, 15, 7, 3, 4));   // evict frame above limit
    script.push_back(limit_row(0));                              // zero acts as one
    script.push_back(access_row(7, 2));
    script.push_back(access_row(3, 5));
    script.push_back(limit_row(31));                             // clamps to frame count
    script.push_back(access_row(8, 1));
    script.push_back(access_row(9, 6));
    script.push_back(access_row(10, 3));
    script.push_back(access_row(11, 4));
    script.push_back(access_row(12, 0));
    script.push_back(access_row(7, 2));
    script.push_back(limit_row(17));
    script.push_back(access_row(15, 0));
    script.push_back(access_row(5, 7));
    script.push_back(access_row(8, 1));
    script.push_back(limit_row(16));

    foreach (script[i]) begin
      if (script[i].is_limit) begin
        write_limit(script[i].limit);
      end else begin
        send_access(script[i].pid, script[i].page, $urandom_range(0, 3), script[i].typed,
                    script[i].want);
      end
    end

    // Random phases: each picks a frame limit, a hot set of 1 to 24 pages drawn
    // without regard to the limit (so hits, free loads and evictions all occur),
    // and an idling style.
    limit_pick = '{0, 1, 2, 15, 16, 17, 31, 8};
    sent = 0;
    while (sent < 900) begin
      pick = $urandom_range(0, 9);
      write_limit(pick < 8 ? limit_pick[pick] : limit_t'($urandom_range(0, 31)));
      hot_size = $urandom_range(1, 24);
      for (int i = 0; i < hot_size; i++) begin
        hot_pid[i]  = pid_t'($urandom_range(0, 15));
        hot_page[i] = page_t'($urandom_range(0, 7));
      end
      quiet     = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 80);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, hot_size - 1);
          pid  = hot_pid[pick];
          page = hot_page[pick];
        end else begin
          pid  = pid_t'($urandom_range(0, 15));
          page = page_t'($urandom_range(0, 7));
        end
        gap = quiet ? 0 : $urandom_range(0, 11);
        send_access(pid, page, gap, 1'b0, '0);
        sent++;
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain: wait for every expected word, bounded, then let the pipe settle.
    waited = 0;
    while (expected_words.size() != 0 && waited < 500) begin
      @(posedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      errors += expected_words.size();
    end
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
